FILE: hw/rtl/stq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stq_pkg;

  localparam int DEPTH       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POP_W       = $clog2(MAX_RESULTS + 1);
  localparam int TICK_W      = 64;
  localparam int ID_W        = 8;
  localparam int DELAY_W     = 32;

  typedef enum logic [1:0] {
    RES_EXPIRED  = 2'd0,
    RES_ACCEPTED = 2'd1,
    RES_REJECTED = 2'd2
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_REJECT,
    S_ADD_SUM,
    S_ADD_WALK,
    S_TICK_INC,
    S_TICK_POP
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sorted_timer_queue.sv
// add: states ADD_SUM and ADD_WALK, then the registered result strobe; the walk stops
//   at the insertion position (0 to DEPTH-1), one entry per cycle on the shared comparator
// add to a full queue: state ADD_REJECT, then the registered result strobe
// tick: states TICK_INC and TICK_POP; one result per cycle per expired timer, the last one flagged
// one item at a time; busy is low only in idle, results cannot be stalled
// rst (synchronous) empties the queue and clears the tick counter
`timescale 1ns / 1ps
`default_nettype none

module sorted_timer_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        kind,
  input  wire logic [stq_pkg::ID_W-1:0]    timer_id,
  input  wire logic [stq_pkg::DELAY_W-1:0] delay,
  output logic                             strobe,
  output logic [1:0]                       event_res,
  output logic [stq_pkg::ID_W-1:0]         expired_id,
  output logic                             last
);

  stq_pkg::state_t state, state_next;

  logic [stq_pkg::TICK_W-1:0] tick_count;
  logic [stq_pkg::TICK_W-1:0] entry_expiry [stq_pkg::DEPTH];
  logic [stq_pkg::ID_W-1:0]   entry_id     [stq_pkg::DEPTH];
  logic [stq_pkg::CNT_W-1:0]  entry_count;

  logic [stq_pkg::ID_W-1:0]    id_q;
  logic [stq_pkg::DELAY_W-1:0] delay_q;
  logic [stq_pkg::TICK_W-1:0]  exp_q;
  logic [stq_pkg::CNT_W-1:0]   pos;
  logic [stq_pkg::POP_W-1:0]   pop_cnt;
  logic                        pend_valid;
  logic [stq_pkg::ID_W-1:0]    pend_id;

  logic                        strobe_q;
  stq_pkg::res_t               res_q;
  logic [stq_pkg::ID_W-1:0]    id_out_q;
  logic                        last_q;

  // shared adder and comparator
  logic [stq_pkg::TICK_W-1:0] add_b;
  logic [stq_pkg::TICK_W-1:0] sum;
  logic [stq_pkg::TICK_W-1:0] cmp_a;
  logic [stq_pkg::TICK_W-1:0] cmp_b;
  logic                       cmp_lt;
  logic [stq_pkg::IDX_W-1:0]  pos_idx;

  logic walk_more;
  logic pop_hit;

  // sequencer outputs
  logic          emit;
  stq_pkg::res_t emit_res;
  logic [stq_pkg::ID_W-1:0] emit_id;
  logic          emit_last;
  logic          do_insert;
  logic          do_pop;

  assign pos_idx = pos[stq_pkg::IDX_W-1:0];
  assign add_b   = (state == stq_pkg::S_TICK_INC) ? stq_pkg::TICK_W'(1)
                                                  : stq_pkg::TICK_W'(delay_q);
  assign sum     = tick_count + add_b;

  always_comb begin
    if (state == stq_pkg::S_ADD_WALK) begin
      cmp_a = entry_expiry[pos_idx];
      cmp_b = exp_q;
    end else begin
      cmp_a = tick_count;
      cmp_b = entry_expiry[0];
    end
  end

  assign cmp_lt = cmp_a < cmp_b;

  assign walk_more = (pos < entry_count) && cmp_lt;
  // head expired when the counter is not below its expiry
  assign pop_hit   = (entry_count != '0) && !cmp_lt &&
                     (pop_cnt < stq_pkg::POP_W'(stq_pkg::MAX_RESULTS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      stq_pkg::S_IDLE: begin
        if (start) begin
          if (!kind) begin
            state_next = stq_pkg::S_TICK_INC;
          end else if (entry_count == stq_pkg::CNT_W'(stq_pkg::DEPTH)) begin
            state_next = stq_pkg::S_ADD_REJECT;
          end else begin
            state_next = stq_pkg::S_ADD_SUM;
          end
        end
      end
      stq_pkg::S_ADD_REJECT: state_next = stq_pkg::S_IDLE;
      stq_pkg::S_ADD_SUM:    state_next = stq_pkg::S_ADD_WALK;
      stq_pkg::S_ADD_WALK: begin
        if (!walk_more) begin
          state_next = stq_pkg::S_IDLE;
        end
      end
      stq_pkg::S_TICK_INC:   state_next = stq_pkg::S_TICK_POP;
      stq_pkg::S_TICK_POP: begin
        if (!pop_hit) begin
          state_next = stq_pkg::S_IDLE;
        end
      end
      default: state_next = stq_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    emit      = 1'b0;
    emit_res  = stq_pkg::RES_EXPIRED;
    emit_id   = pend_id;
    emit_last = 1'b0;
    do_insert = 1'b0;
    do_pop    = 1'b0;
    unique case (state)
      stq_pkg::S_IDLE, stq_pkg::S_ADD_SUM, stq_pkg::S_TICK_INC: begin
      end
      stq_pkg::S_ADD_REJECT: begin
        emit      = 1'b1;
        emit_res  = stq_pkg::RES_REJECTED;
        emit_id   = id_q;
        emit_last = 1'b1;
      end
      stq_pkg::S_ADD_WALK: begin
        if (!walk_more) begin
          do_insert = 1'b1;
          emit      = 1'b1;
          emit_res  = stq_pkg::RES_ACCEPTED;
          emit_id   = id_q;
          emit_last = 1'b1;
        end
      end
      stq_pkg::S_TICK_POP: begin
        // the previous pop goes out once we know whether another follows
        do_pop    = pop_hit;
        emit      = pend_valid;
        emit_last = !pop_hit;
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != stq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stq_pkg::S_IDLE;
      tick_count  <= '0;
      entry_count <= '0;
      pend_valid  <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      state    <= state_next;
      strobe_q <= emit;

      if (state == stq_pkg::S_TICK_INC) begin
        tick_count <= sum;
      end
      if (do_insert) begin
        entry_count <= entry_count + 1'b1;
      end else if (do_pop) begin
        entry_count <= entry_count - 1'b1;
      end

      if (state == stq_pkg::S_TICK_INC) begin
        pend_valid <= 1'b0;
      end else if (do_pop) begin
        pend_valid <= 1'b1;
      end else if (state == stq_pkg::S_TICK_POP) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // payload and queue storage
  always_ff @(posedge clk) begin
    if (state == stq_pkg::S_IDLE && start) begin
      id_q    <= timer_id;
      delay_q <= delay;
    end
    if (state == stq_pkg::S_ADD_SUM) begin
      exp_q <= sum;
      pos   <= '0;
    end else if (state == stq_pkg::S_ADD_WALK && walk_more) begin
      pos <= pos + 1'b1;
    end

    if (state == stq_pkg::S_TICK_INC) begin
      pop_cnt <= '0;
    end else if (do_pop) begin
      pop_cnt <= pop_cnt + 1'b1;
      pend_id <= entry_id[0];
    end

    if (emit) begin
      res_q    <= emit_res;
      id_out_q <= emit_id;
      last_q   <= emit_last;
    end

    for (int i = 0; i < stq_pkg::DEPTH; i++) begin
      if (do_insert) begin
        if (stq_pkg::CNT_W'(i) == pos) begin
          entry_expiry[i] <= exp_q;
          entry_id[i]     <= id_q;
        end else if (i > 0 && stq_pkg::CNT_W'(i) > pos) begin
          entry_expiry[i] <= entry_expiry[i-1];
          entry_id[i]     <= entry_id[i-1];
        end
      end else if (do_pop && i < stq_pkg::DEPTH - 1) begin
        entry_expiry[i] <= entry_expiry[i+1];
        entry_id[i]     <= entry_id[i+1];
      end
    end
  end

  assign strobe     = strobe_q;
  assign event_res  = res_q;
  assign expired_id = id_out_q;
  assign last       = last_q;

  a_reset_clean: assert property (@(posedge clk)
    rst |=> (state == stq_pkg::S_IDLE && entry_count == '0 && !strobe))
    else $error("state not clean after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= stq_pkg::CNT_W'(stq_pkg::DEPTH))
    else $error("queue count beyond depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    state == stq_pkg::S_ADD_WALK |-> pos <= entry_count)
    else $error("insertion walk passed the queue end");

  a_add_last: assert property (@(posedge clk) disable iff (rst)
    strobe && event_res != stq_pkg::RES_EXPIRED |-> last)
    else $error("add result without last flag");

  a_accept_grows: assert property (@(posedge clk) disable iff (rst)
    strobe && event_res == stq_pkg::RES_ACCEPTED && !$past(rst) |->
      entry_count == stq_pkg::CNT_W'($past(entry_count) + 1'b1))
    else $error("accepted add did not grow the queue");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == stq_pkg::S_IDLE |-> !pend_valid)
    else $error("expired timer left unreported");

endmodule

`default_nettype wire

FILE: dv/tb_sorted_timer_queue.sv
`timescale 1ns / 1ps

module tb_sorted_timer_queue;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_CMDS = 200;

  typedef struct {
    bit                        kind;
    bit [stq_pkg::ID_W-1:0]    id;
    bit [stq_pkg::DELAY_W-1:0] dly;
  } timer_cmd_t;

  typedef struct {
    stq_pkg::res_t          res;
    bit [stq_pkg::ID_W-1:0] id;
    bit                     last;
  } timer_event_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        kind = 1'b0;
  logic [stq_pkg::ID_W-1:0]    timer_id = '0;
  logic [stq_pkg::DELAY_W-1:0] delay = '0;
  logic                        busy;
  logic                        strobe;
  logic [1:0]                  event_res;
  logic [stq_pkg::ID_W-1:0]    expired_id;
  logic                        last;

  timer_cmd_t   pending_cmds[$];
  timer_event_t expected_events[$];

  // shadow of the timer queue
  bit [stq_pkg::TICK_W-1:0] shadow_tick;
  bit [stq_pkg::TICK_W-1:0] shadow_expiry[stq_pkg::DEPTH];
  bit [stq_pkg::ID_W-1:0]   shadow_id[stq_pkg::DEPTH];
  int                       shadow_count;

  int mismatch_count;
  int cycle_count;
  int gap_left;
  int burst_left;

  sorted_timer_queue u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .timer_id   (timer_id),
    .delay      (delay),
    .strobe     (strobe),
    .event_res  (event_res),
    .expired_id (expired_id),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void queue_cmd(bit k, bit [stq_pkg::ID_W-1:0] id,
                                    bit [stq_pkg::DELAY_W-1:0] dly);
    timer_cmd_t c;
    c.kind = k;
    c.id   = id;
    c.dly  = dly;
    pending_cmds.push_back(c);
  endfunction

  function automatic void push_event(stq_pkg::res_t res, bit [stq_pkg::ID_W-1:0] id, bit lst);
    timer_event_t e;
    e.res  = res;
    e.id   = id;
    e.last = lst;
    expected_events.push_back(e);
  endfunction

  // advance the shadow queue by one command and record the events it causes
  function automatic void apply_timer_cmd(bit k, bit [stq_pkg::ID_W-1:0] id,
                                          bit [stq_pkg::DELAY_W-1:0] dly);
    bit [stq_pkg::TICK_W-1:0] exp_tick;
    int pos;
    int n;
    if (k) begin
      if (shadow_count >= stq_pkg::DEPTH) begin
        push_event(stq_pkg::RES_REJECTED, id, 1'b1);
      end else begin
        exp_tick = shadow_tick + stq_pkg::TICK_W'(dly);
        pos = 0;
        while (pos < shadow_count && shadow_expiry[pos] < exp_tick) pos++;
        for (int j = shadow_count; j > pos; j--) begin
          shadow_expiry[j] = shadow_expiry[j-1];
          shadow_id[j]     = shadow_id[j-1];
        end
        shadow_expiry[pos] = exp_tick;
        shadow_id[pos]     = id;
        shadow_count++;
        push_event(stq_pkg::RES_ACCEPTED, id, 1'b1);
      end
    end else begin
      shadow_tick = shadow_tick + 1;
      n = 0;
      while (n < stq_pkg::MAX_RESULTS && shadow_count > 0 &&
             shadow_expiry[0] <= shadow_tick) begin
        push_event(stq_pkg::RES_EXPIRED, shadow_id[0], 1'b0);
        for (int j = 1; j < shadow_count; j++) begin
          shadow_expiry[j-1] = shadow_expiry[j];
          shadow_id[j-1]     = shadow_id[j];
        end
        shadow_count--;
        n++;
      end
      if (n > 0) expected_events[expected_events.size()-1].last = 1'b1;
    end
  endfunction

  // driver: bursts of commands separated by random gaps
  always @(posedge clk) begin
    timer_cmd_t c;
    if (rst) begin
      start    <= 1'b0;
      kind     <= 1'b0;
      timer_id <= '0;
      delay    <= '0;
    end else begin
      if (start && !busy) apply_timer_cmd(kind, timer_id, delay);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          start    <= 1'b1;
          kind     <= c.kind;
          timer_id <= c.id;
          delay    <= c.dly;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is a transfer that cannot be held off
  always @(posedge clk) begin
    timer_event_t e;
    if (!rst && strobe) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_res %0d expired_id %0d last %0d",
               event_res, expired_id, last);
        mismatch_count++;
      end else begin
        e = expected_events.pop_front();
        if (event_res !== e.res) begin
          $error("event_res: expected %0d, actual %0d", e.res, event_res);
          mismatch_count++;
        end
        if (expired_id !== e.id) begin
          $error("expired_id: expected %0d, actual %0d", e.id, expired_id);
          mismatch_count++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, actual %0d", e.last, last);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int r;
    bit [stq_pkg::DELAY_W-1:0] dly;
    shadow_tick    = '0;
    shadow_count   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    gap_left       = 0;
    burst_left     = 0;

    // ticks on an empty queue
    queue_cmd(1'b0, 8'hFF, '1);
    queue_cmd(1'b0, 8'h00, '0);
    // equal expiries: the later add goes ahead of the earlier one
    queue_cmd(1'b1, 8'h00, '0);
    queue_cmd(1'b1, 8'hFF, '0);
    queue_cmd(1'b0, 8'h00, '0);
    // fill the queue, short entries go ahead of longer ones
    for (int i = 0; i < stq_pkg::DEPTH; i++) begin
      queue_cmd(1'b1, stq_pkg::ID_W'(i + 16), stq_pkg::DELAY_W'(i % 2));
    end
    queue_cmd(1'b1, 8'hEE, 32'd3);
    // whole queue expires on one tick
    queue_cmd(1'b0, 8'h5A, 32'h1234_5678);
    // far expiry stays queued, a near one lands in front of it
    queue_cmd(1'b1, 8'hA5, '1);
    queue_cmd(1'b1, 8'h3C, 32'd2);
    queue_cmd(1'b0, 8'h00, '0);
    queue_cmd(1'b0, 8'h00, '0);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(0, 39);
      if (r == 0) dly = $urandom;
      else if (r < 10) dly = $urandom_range(0, 3);
      else dly = $urandom_range(0, 30);
      queue_cmd(1'($urandom_range(0, 1)), stq_pkg::ID_W'($urandom_range(0, 255)), dly);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
